>>> src/pgtd_pkg.sv
`default_nettype none

package pgtd_pkg;

    localparam int VALUE_W = 16;
    localparam int IDX_W   = 11;
    localparam int CAND_W  = VALUE_W + 1;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int REG_W   = PADDR_W - 2;

    localparam logic [IDX_W-1:0]   LIMIT_RESET = 11'd1024;
    localparam logic [VALUE_W-1:0] FIRST_PRIME = 16'd2;
    localparam logic [CAND_W-1:0]  FIRST_CAND  = 17'd3;
    localparam logic [CAND_W-1:0]  CAND_STEP   = 17'd2;

    localparam logic [REG_W-1:0] REG_LIMIT = 1'b0;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [VALUE_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic is_zero;
    } rem_rsp_t;

endpackage

`default_nettype wire

>>> src/pgtd_if.sv
`default_nettype none

interface pgtd_req_if import pgtd_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface pgtd_rsp_if import pgtd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] prime_value;
    logic [IDX_W-1:0]   prime_index;
    logic               limit_reached;

    modport source (output valid, output prime_value, output prime_index,
                    output limit_reached, input ready);
    modport sink   (input valid, input prime_value, input prime_index,
                    input limit_reached, output ready);
endinterface

`default_nettype wire

>>> src/pgtd_apb_regs.sv
`default_nettype none

module pgtd_apb_regs
    import pgtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [IDX_W-1:0]   limit
);

    logic [IDX_W-1:0] limit_reg;
    logic [IDX_W-1:0] limit_next;
    logic [REG_W-1:0] reg_sel;
    logic             wr_en;

    assign reg_sel = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en && (reg_sel == REG_LIMIT))
        begin
            limit_next = pwdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_LIMIT)
        begin
            prdata = {{(DATA_W-IDX_W){1'b0}}, limit_reg};
        end
    end

    assign limit = limit_reg;

endmodule

`default_nettype wire

>>> src/pgtd_rem_unit.sv
`default_nettype none

// Restoring remainder, one quotient bit per cycle.
module pgtd_rem_unit
    import pgtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t rem_req,
    output rem_rsp_t rem_rsp
);

    localparam int STEP_W = $clog2(VALUE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

    logic               busy_reg;
    logic               busy_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               done_reg;
    logic               done_next;
    logic               zero_reg;
    logic               zero_next;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [VALUE_W-1:0] dvd_reg;
    logic [VALUE_W-1:0] dvd_next;
    logic [VALUE_W-1:0] dvs_reg;
    logic [VALUE_W-1:0] dvs_next;
    logic [VALUE_W:0]   trial;
    logic [VALUE_W:0]   diff;
    logic [VALUE_W-1:0] rem_step;

    assign trial    = {rem_reg, dvd_reg[VALUE_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_step = diff[VALUE_W] ? trial[VALUE_W-1:0] : diff[VALUE_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            rem_next  = rem_step;
            dvd_next  = {dvd_reg[VALUE_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (rem_step == '0);
            end
        end
        else if (rem_req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = rem_req.dividend;
            dvs_next  = rem_req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
    end

    assign rem_rsp.done    = done_reg;
    assign rem_rsp.is_zero = zero_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> !busy_reg)
        else $error("remainder done while still stepping");

    assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> $past(busy_reg))
        else $error("remainder done without a division in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < dvs_reg || dvs_reg == '0)
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> src/prime_generator_trial_division_unit.sv
`default_nettype none
// From acceptance, a table hit (first prime after restart) passes decide, fetch and emit,
// a limit word decide and emit. A new prime passes decide, then per trial division over
// all candidates tested a table read, square, compare and division, then prime and emit.
// One request at a time; the next is taken the cycle after the word is loaded for output.
// Reset: counters to their seed, candidate 3, limit 1024; table entry 0 reads as 2,
// other entries are written before they are read, so there is no clearing pass.
module prime_generator_trial_division_unit
    import pgtd_pkg::*;
#(
    parameter int unsigned PRIME_TABLE_DEPTH = 1024
)(
    input  logic               clk,
    input  logic               rst_n,
    pgtd_req_if.sink           req,
    pgtd_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int ADDR_W  = $clog2(PRIME_TABLE_DEPTH);
    localparam int FOUND_W = $clog2(PRIME_TABLE_DEPTH + 1);
    localparam int CNT_W   = (FOUND_W > IDX_W) ? FOUND_W : IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PRIME_TABLE_DEPTH);
    localparam int SQ_W    = 2 * VALUE_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DECIDE   = 9'b000000010,
        ST_FETCH    = 9'b000000100,
        ST_TEST_RD  = 9'b000001000,
        ST_TEST_SQ  = 9'b000010000,
        ST_TEST_CMP = 9'b000100000,
        ST_TEST_DIV = 9'b001000000,
        ST_PRIME    = 9'b010000000,
        ST_EMIT     = 9'b100000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    found_reg;
    logic [CNT_W-1:0]    found_next;
    logic [CNT_W-1:0]    emitted_reg;
    logic [CNT_W-1:0]    emitted_next;
    logic [CNT_W-1:0]    trial_reg;
    logic [CNT_W-1:0]    trial_next;
    logic [CAND_W-1:0]   cand_reg;
    logic [CAND_W-1:0]   cand_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [VALUE_W-1:0]  res_value_reg;
    logic [VALUE_W-1:0]  res_value_next;
    logic [IDX_W-1:0]    res_index_reg;
    logic [IDX_W-1:0]    res_index_next;
    logic                res_limit_reg;
    logic                res_limit_next;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic                out_limit_reg;
    logic [SQ_W-1:0]     sq_reg;

    logic [VALUE_W-1:0]  prime_mem [PRIME_TABLE_DEPTH];
    logic [VALUE_W-1:0]  rdata_reg;
    logic                rd_zero_reg;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                mem_we;
    logic [VALUE_W-1:0]  p_data;
    logic [CAND_W-1:0]   cand_step;
    logic [VALUE_W-1:0]  cand_wrap;

    logic [IDX_W-1:0]    cfg_limit;
    logic                over_limit;
    logic                slot_free;
    rem_req_t            rem_req;
    rem_rsp_t            rem_rsp;

    pgtd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (cfg_limit)
    );

    pgtd_rem_unit u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rem_req (rem_req),
        .rem_rsp (rem_rsp)
    );

    // entry zero is the fixed seed prime
    assign p_data     = rd_zero_reg ? FIRST_PRIME : rdata_reg;
    assign cand_step  = cand_reg + CAND_STEP;
    assign cand_wrap  = cand_reg[VALUE_W-1:0] + CAND_STEP[VALUE_W-1:0];
    assign over_limit = (emitted_reg >= CNT_W'(cfg_limit)) || (emitted_reg >= DEPTH_C);
    assign slot_free  = !out_valid_reg || rsp.ready;

    assign rem_req.start    = (state_reg == ST_TEST_CMP) &&
                              !(sq_reg > SQ_W'(cand_reg));
    assign rem_req.dividend = cand_reg[VALUE_W-1:0];
    assign rem_req.divisor  = p_data;

    always_comb
    begin
        state_next     = state_reg;
        found_next     = found_reg;
        emitted_next   = emitted_reg;
        trial_next     = trial_reg;
        cand_next      = cand_reg;
        res_value_next = res_value_reg;
        res_index_next = res_index_reg;
        res_limit_next = res_limit_reg;
        mem_re         = 1'b0;
        mem_raddr      = trial_reg[ADDR_W-1:0];
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.restart)
                    begin
                        found_next   = CNT_W'(1);
                        emitted_next = '0;
                        cand_next    = FIRST_CAND;
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_index_next = emitted_reg[IDX_W-1:0];
                if (over_limit)
                begin
                    res_value_next = '0;
                    res_limit_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (emitted_reg < found_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = emitted_reg[ADDR_W-1:0];
                    state_next = ST_FETCH;
                end
                else
                begin
                    trial_next = '0;
                    state_next = ST_TEST_RD;
                end
            end
            ST_FETCH:
            begin
                res_value_next = p_data;
                res_limit_next = 1'b0;
                emitted_next   = emitted_reg + 1'b1;
                state_next     = ST_EMIT;
            end
            ST_TEST_RD:
            begin
                // out of stored primes: candidate survived every divisor
                if (trial_reg >= found_reg)
                begin
                    state_next = ST_PRIME;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_TEST_SQ;
                end
            end
            ST_TEST_SQ:
            begin
                state_next = ST_TEST_CMP;
            end
            ST_TEST_CMP:
            begin
                if (sq_reg > SQ_W'(cand_reg))
                begin
                    state_next = ST_PRIME;
                end
                else
                begin
                    state_next = ST_TEST_DIV;
                end
            end
            ST_TEST_DIV:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.is_zero)
                    begin
                        // composite: skip to the next odd candidate, or emit a limit word if it leaves 16 bits
                        if (cand_step[VALUE_W])
                        begin
                            cand_next      = {1'b0, cand_step[VALUE_W-1:0]};
                            res_value_next = '0;
                            res_limit_next = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        else
                        begin
                            cand_next  = cand_step;
                            trial_next = '0;
                            state_next = ST_TEST_RD;
                        end
                    end
                    else
                    begin
                        trial_next = trial_reg + 1'b1;
                        state_next = ST_TEST_RD;
                    end
                end
            end
            ST_PRIME:
            begin
                if (found_reg >= DEPTH_C)
                begin
                    res_value_next = '0;
                    res_limit_next = 1'b1;
                end
                else
                begin
                    mem_we         = 1'b1;
                    found_next     = found_reg + 1'b1;
                    emitted_next   = emitted_reg + 1'b1;
                    cand_next      = {1'b0, cand_wrap};
                    res_value_next = cand_reg[VALUE_W-1:0];
                    res_limit_next = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            found_reg     <= CNT_W'(1);
            emitted_reg   <= '0;
            trial_reg     <= '0;
            cand_reg      <= FIRST_CAND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            emitted_reg   <= emitted_next;
            trial_reg     <= trial_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_index_reg <= res_index_next;
        res_limit_reg <= res_limit_next;
        sq_reg        <= {{VALUE_W{1'b0}}, p_data} * {{VALUE_W{1'b0}}, p_data};
        if ((state_reg == ST_EMIT) && slot_free)
        begin
            out_value_reg <= res_value_reg;
            out_index_reg <= res_index_reg;
            out_limit_reg <= res_limit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prime_mem[found_reg[ADDR_W-1:0]] <= cand_reg[VALUE_W-1:0];
        end
        if (mem_re)
        begin
            rdata_reg   <= prime_mem[mem_raddr];
            rd_zero_reg <= (mem_raddr == '0);
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.prime_value   = out_value_reg;
    assign rsp.prime_index   = out_index_reg;
    assign rsp.limit_reached = out_limit_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_EMIT))
        else $error("result word raised outside the emit step");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.limit_reached |-> rsp.prime_value == '0)
        else $error("limit word carries a prime value");

    assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= found_reg && found_reg <= DEPTH_C)
        else $error("prime counters out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TEST_RD |-> cand_reg[0] && !cand_reg[VALUE_W])
        else $error("candidate not odd or left 16 bits during the search");

endmodule

`default_nettype wire

>>> sim/tb_prime_generator_trial_division_unit.sv
`default_nettype none

module tb_prime_generator_trial_division_unit;
    import pgtd_pkg::*;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_LIMIT, 2'b00};

    typedef struct packed {
        logic [VALUE_W-1:0] prime_value;
        logic [IDX_W-1:0]   prime_index;
        logic               limit_reached;
    } prime_word_t;

    logic clk;
    logic rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    pgtd_req_if req_ch ();
    pgtd_rsp_if rsp_ch ();

    prime_generator_trial_division_unit #(
        .PRIME_TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Own copy of the sequence state
    logic [VALUE_W-1:0] known_primes [TABLE_DEPTH];
    int unsigned        primes_known;
    int unsigned        primes_given;
    int unsigned        candidate;
    logic [IDX_W-1:0]   limit_reg;

    prime_word_t expected_words [$];
    int          mismatches;
    bit          sender_gaps;
    bit          receiver_gaps;
    int unsigned ready_hold;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_primes();
        foreach (known_primes[i])
            known_primes[i] = '0;
        known_primes[0] = FIRST_PRIME;
        primes_known    = 1;
        primes_given    = 0;
        candidate       = 3;
    endfunction

    function automatic bit passes_trial_division(int unsigned cand);
        int unsigned p;
        for (int unsigned i = 0; i < primes_known && i < TABLE_DEPTH; i++)
        begin
            p = known_primes[i];
            if (p * p > cand)
                break;
            if (cand % p == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic prime_word_t next_prime_word(bit restart);
        prime_word_t w;
        int unsigned cap;
        int unsigned cand;
        if (restart)
            clear_primes();
        cap = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
        w.prime_value   = '0;
        w.prime_index   = primes_given[IDX_W-1:0];
        w.limit_reached = 1'b1;
        if (primes_given >= cap)
            return w;
        if (primes_given < primes_known)
        begin
            w.prime_value = known_primes[primes_given];
        end
        else
        begin
            cand = candidate;
            while (cand <= 32'hFFFF && !passes_trial_division(cand))
                cand += 2;
            if (cand > 32'hFFFF || primes_known >= TABLE_DEPTH)
            begin
                candidate = cand & 32'hFFFF;
                return w;
            end
            known_primes[primes_known] = cand[VALUE_W-1:0];
            primes_known++;
            w.prime_value = cand[VALUE_W-1:0];
            candidate = (cand + 2) & 32'hFFFF;
        end
        w.limit_reached = 1'b0;
        primes_given++;
        return w;
    endfunction

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    initial
    begin : drive_ready
        int unsigned stall_left;
        int unsigned n;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (ready_hold != 0)
            begin
                n = ready_hold;
                ready_hold = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
                @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (receiver_gaps)
                    stall_left = pick_gap();
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        prime_word_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word: value %0d index %0d limit %0b",
                    rsp_ch.prime_value, rsp_ch.prime_index, rsp_ch.limit_reached));
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_ch.prime_value !== want.prime_value)
                    note_mismatch($sformatf("prime_value: expected %0d, got %0d (index %0d)",
                        want.prime_value, rsp_ch.prime_value, want.prime_index));
                if (rsp_ch.prime_index !== want.prime_index)
                    note_mismatch($sformatf("prime_index: expected %0d, got %0d",
                        want.prime_index, rsp_ch.prime_index));
                if (rsp_ch.limit_reached !== want.limit_reached)
                    note_mismatch($sformatf("limit_reached: expected %0b, got %0b (index %0d)",
                        want.limit_reached, rsp_ch.limit_reached, want.prime_index));
            end
        end
    end

    // Called at a rising edge; leaves valid high so the next word can follow at once
    task automatic send_request(input bit restart);
        int unsigned gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap != 0)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_words.push_back(next_prime_word(restart));
    endtask

    // Drop valid and wait until every expected word is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input bit wr, input logic [DATA_W-1:0] data,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_limit_reg();
        logic [DATA_W-1:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        if (rdata[IDX_W-1:0] !== limit_reg)
            note_mismatch($sformatf("limit register read: expected %0d, got %0d",
                limit_reg, rdata[IDX_W-1:0]));
    endtask

    task automatic write_limit(input logic [IDX_W-1:0] value);
        logic [DATA_W-1:0] rdata;
        settle();
        apb_transfer(1'b1, DATA_W'(value), rdata);
        limit_reg = value;
        check_limit_reg();
    endtask

    task automatic test_first_primes();
        check_limit_reg();
        repeat (6) send_request(1'b0);
    endtask

    task automatic test_restart();
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
    endtask

    task automatic test_limit_zero();
        write_limit('0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Register survives a restart; raising it lets the sequence carry on
    task automatic test_limit_raise();
        write_limit(11'd1);
        send_request(1'b1);
        send_request(1'b0);
        write_limit(11'd4);
        repeat (4) send_request(1'b0);
    endtask

    // Whole table, then limits above and below the table depth
    task automatic test_full_sequence();
        write_limit(LIMIT_RESET);
        send_request(1'b1);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
        begin
            sender_gaps   = !(i >= 300 && i < 500);
            receiver_gaps = sender_gaps;
            send_request(1'b0);
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        write_limit(11'h7FF);
        repeat (2) send_request(1'b0);
        write_limit(LIMIT_RESET - 1);
        send_request(1'b0);
    endtask

    task automatic test_backpressure();
        write_limit(LIMIT_RESET);
        sender_gaps = 1'b0;
        ready_hold  = 600;
        send_request(1'b1);
        repeat (30) send_request(1'b0);
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        logic [IDX_W-1:0] lim;
        bit               noisy;
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 4))
                0: lim = '0;
                1: lim = 11'd1;
                2: lim = IDX_W'($urandom_range(2, 16));
                3: lim = IDX_W'($urandom_range(17, 200));
                default: lim = IDX_W'($urandom_range(0, 2047));
            endcase
            write_limit(lim);
            noisy = (ph % 4 == 3);
            send_request(1'b1);
            for (int i = 0; i < 59; i++)
                send_request(noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        mismatches     = 0;
        ready_hold     = 0;
        sender_gaps    = 1'b1;
        receiver_gaps  = 1'b1;
        clear_primes();
        limit_reg = LIMIT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_primes();
        test_restart();
        test_limit_zero();
        test_limit_raise();
        test_full_sequence();
        test_backpressure();
        test_random_mix();

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
src/pgtd_pkg.sv
src/pgtd_if.sv
src/pgtd_apb_regs.sv
src/pgtd_rem_unit.sv
src/prime_generator_trial_division_unit.sv
sim/tb_prime_generator_trial_division_unit.sv
